// ===== sv/npcm_pkg.sv =====
// npcm_pkg: shared constants and types for the nearest palette color mapper
// no dependencies
`default_nettype none
package npcm_pkg;
    localparam int PaletteSize = 256;
    localparam int PosW = 8;
    localparam logic [PosW-1:0] LastPos = PosW'(PaletteSize - 1);
    localparam logic [10:0] StartDist = 11'd1000;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_MAP   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  entry_index;
        logic [31:0] pixel_word;
    } t_in;

    typedef struct packed {
        logic [7:0]  palette_index;
        logic [31:0] mapped_pixel;
    } t_out;
endpackage
`default_nettype wire

// ===== sv/npcm_if.sv =====
// npcm_if: valid/ready channel carrying one payload struct
// depends on npcm_pkg
`default_nettype none
interface npcm_in_if;
    logic valid;
    logic ready;
    npcm_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface npcm_out_if;
    logic valid;
    logic ready;
    npcm_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/nearest_palette_color_mapper_core.sv =====
// nearest_palette_color_mapper_core: palette load, green sort, index build, map
// depends on npcm_pkg and npcm_if
`default_nettype none
// One transaction in, one transaction out. The palette (256 x 24) and the green
// start table (256 x 8) are single-port memories under one sequencer. Each step
// drives one address per memory and uses the registered read data the next
// cycle. The input is ready only in idle, so one transaction is in work at a
// time. A finished result waits in the output register while the next
// transaction is accepted. A load writes one entry, and an unused command goes
// straight to done. A build is a selection sort. For each position k it reads
// entry k and scans entries k+1 up to the last, with one read and one compare
// per entry. It then writes both swapped entries and steps on. When the green
// value moves, the start table is filled at one entry a cycle. A map reads the
// green start, then probes candidates, alternating up and down and skipping a
// direction that has already stopped, and then reads the winning entry. The
// candidate count is set by how far the outward green walk runs before the
// early stop, typically a handful. Reading palette entries that were never
// loaded gives unspecified results.
module nearest_palette_color_mapper_core (
    input  wire i_clk,
    input  wire i_rst_n,
    npcm_in_if.sink    i_in,
    npcm_out_if.source o_out
);
    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_LOAD  = 16'b0000_0000_0000_0010,  // write one palette entry
        S_BK    = 16'b0000_0000_0000_0100,  // read palette[k]
        S_BKD   = 16'b0000_0000_0000_1000,  // take palette[k] as first candidate
        S_BRD   = 16'b0000_0000_0001_0000,  // read palette[m]
        S_BCMP  = 16'b0000_0000_0010_0000,  // compare green of palette[m]
        S_BSWA  = 16'b0000_0000_0100_0000,  // palette[pos] <= old k entry
        S_BSWB  = 16'b0000_0000_1000_0000,  // palette[k] <= smallest entry
        S_BFILL = 16'b0000_0001_0000_0000,  // start table fill
        S_BNEXT = 16'b0000_0010_0000_0000,
        S_MGS   = 16'b0000_0100_0000_0000,  // read green start
        S_MSTRT = 16'b0000_1000_0000_0000,
        S_MSEL  = 16'b0001_0000_0000_0000,  // pick direction, read candidate
        S_MPRB  = 16'b0010_0000_0000_0000,  // probe on registered data
        S_MOUT  = 16'b0100_0000_0000_0000,  // read winning entry
        S_DONE  = 16'b1000_0000_0000_0000
    } t_state;

    t_state r_state;
    logic [23:0] r_pal [0:255];
    logic [7:0]  r_gsi [0:255];
    logic [23:0] r_prd;
    logic [7:0]  r_grd;

    npcm_pkg::t_in r_req;
    npcm_pkg::t_out r_res;
    logic r_ovalid;

    // build registers
    logic [7:0] r_k, r_m, r_pos, r_val, r_prev, r_start, r_fk;
    logic [8:0] r_fm, r_ftop;
    logic [23:0] r_kent, r_pent;
    logic r_bend;
    // map registers
    logic [8:0]  r_up;
    logic signed [8:0] r_dn;
    logic [10:0] r_bestd;
    logic [7:0]  r_best;
    logic        r_dirup;

    logic [7:0] w_pr, w_pg, w_pb;
    assign w_pr = r_req.pixel_word[23:16];
    assign w_pg = r_req.pixel_word[15:8];
    assign w_pb = r_req.pixel_word[7:0];

    // result register is free when empty or being taken this cycle
    logic w_fire;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_fire = (r_state == S_DONE) && (!r_ovalid || o_out.ready);
    assign o_out.valid = r_ovalid;
    assign o_out.data = r_res;

    // probe arithmetic on registered palette data
    logic [7:0] w_eg;
    logic signed [9:0] w_gk;
    logic [9:0] w_gabs;
    logic [7:0] w_db, w_dr;
    logic [10:0] w_d1, w_d2;
    logic w_stop;
    always_comb begin
        w_eg = r_prd[15:8];
        if (r_dirup) w_gk = $signed({2'b00, w_eg}) - $signed({2'b00, w_pg});
        else w_gk = $signed({2'b00, w_pg}) - $signed({2'b00, w_eg});
        w_stop = ($signed({{2{w_gk[9]}}, w_gk}) >= $signed({1'b0, r_bestd}));
        w_gabs = w_gk[9] ? 10'(-w_gk) : 10'(w_gk);
        w_db = (r_prd[7:0] > w_pb) ? (r_prd[7:0] - w_pb) : (w_pb - r_prd[7:0]);
        w_dr = (r_prd[23:16] > w_pr) ? (r_prd[23:16] - w_pr) : (w_pr - r_prd[23:16]);
        w_d1 = {1'b0, w_gabs} + {3'b000, w_db};
        w_d2 = w_d1 + {3'b000, w_dr};
    end

    logic w_more_up, w_more_dn;
    logic [7:0] w_ustart;
    assign w_more_up = (r_up < 9'(npcm_pkg::PaletteSize));
    assign w_more_dn = !r_dn[8];
    assign w_ustart = (r_grd > npcm_pkg::LastPos) ? npcm_pkg::LastPos : r_grd;

    // memory address/write control
    logic [7:0] w_pa, w_ga, w_gwd;
    logic w_pwe, w_gwe;
    logic [23:0] w_pwd;
    logic [8:0] w_head;
    always_comb begin
        w_pa = r_best;
        w_pwe = 1'b0;
        w_pwd = r_kent;
        w_ga = w_pg;
        w_gwe = 1'b0;
        // first entry of a green run starts halfway into the previous run
        w_head = ({1'b0, r_start} + {1'b0, r_fk}) >> 1;
        w_gwd = (r_fm == {1'b0, r_prev}) ? w_head[7:0] : r_fk;
        unique case (r_state)
            S_LOAD: begin
                w_pa = r_req.entry_index;
                w_pwd = r_req.pixel_word[23:0];
                w_pwe = ({1'b0, r_req.entry_index} < 9'(npcm_pkg::PaletteSize));
            end
            S_BK: w_pa = r_k;
            S_BRD: w_pa = r_m;
            S_BSWA: begin
                w_pa = r_pos;
                w_pwd = r_kent;
                w_pwe = 1'b1;
            end
            S_BSWB: begin
                w_pa = r_k;
                w_pwd = r_pent;
                w_pwe = 1'b1;
            end
            S_BFILL: begin
                w_ga = r_fm[7:0];
                w_gwe = 1'b1;
            end
            S_MSEL: w_pa = r_dirup ? r_up[7:0] : r_dn[7:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pwe) r_pal[w_pa] <= w_pwd;
        r_prd <= r_pal[w_pa];
        if (w_gwe) r_gsi[w_ga] <= w_gwd;
        r_grd <= r_gsi[w_ga];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_fire) begin
            r_ovalid <= 1'b1;
        end else if (o_out.valid && o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_req <= i_in.data;
                        unique case (npcm_pkg::t_cmd'(i_in.data.command))
                            npcm_pkg::CMD_LOAD: r_state <= S_LOAD;
                            npcm_pkg::CMD_BUILD: begin
                                r_k <= '0;
                                r_prev <= '0;
                                r_start <= '0;
                                r_bend <= 1'b0;
                                r_state <= S_BK;
                            end
                            npcm_pkg::CMD_MAP: r_state <= S_MGS;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_LOAD: r_state <= S_DONE;
                S_BK: r_state <= S_BKD;
                S_BKD: begin
                    r_kent <= r_prd;
                    r_pent <= r_prd;
                    r_val <= r_prd[15:8];
                    r_pos <= r_k;
                    r_m <= r_k + 8'd1;
                    if (r_k == npcm_pkg::LastPos) r_state <= S_BSWA;
                    else r_state <= S_BRD;
                end
                S_BRD: r_state <= S_BCMP;
                S_BCMP: begin
                    // strict less-than keeps the first smallest entry
                    if (r_prd[15:8] < r_val) begin
                        r_pos <= r_m;
                        r_pent <= r_prd;
                        r_val <= r_prd[15:8];
                    end
                    if (r_m == npcm_pkg::LastPos) begin
                        r_state <= S_BSWA;
                    end else begin
                        r_m <= r_m + 8'd1;
                        r_state <= S_BRD;
                    end
                end
                S_BSWA: r_state <= S_BSWB;
                S_BSWB: begin
                    if (r_val != r_prev) begin
                        r_fm <= {1'b0, r_prev};
                        r_ftop <= {1'b0, r_val};
                        r_fk <= r_k;
                        r_state <= S_BFILL;
                    end else begin
                        r_state <= S_BNEXT;
                    end
                end
                S_BFILL: begin
                    if (r_fm + 9'd1 >= r_ftop) begin
                        if (r_bend) begin
                            r_state <= S_DONE;
                        end else begin
                            r_prev <= r_val;
                            r_start <= r_k;
                            r_state <= S_BNEXT;
                        end
                    end else begin
                        r_fm <= r_fm + 9'd1;
                    end
                end
                S_BNEXT: begin
                    if (r_k == npcm_pkg::LastPos) begin
                        // closing fill up to the top of the table
                        r_fm <= {1'b0, r_prev};
                        r_ftop <= 9'd256;
                        r_fk <= npcm_pkg::LastPos;
                        r_bend <= 1'b1;
                        r_state <= S_BFILL;
                    end else begin
                        r_k <= r_k + 8'd1;
                        r_state <= S_BK;
                    end
                end
                S_MGS: r_state <= S_MSTRT;
                S_MSTRT: begin
                    r_up <= {1'b0, w_ustart};
                    r_dn <= $signed({1'b0, w_ustart}) - 9'sd1;
                    r_bestd <= npcm_pkg::StartDist;
                    r_best <= '0;
                    r_dirup <= 1'b1;
                    r_state <= S_MSEL;
                end
                S_MSEL: begin
                    // alternate up and down, skipping a direction that stopped
                    if (r_dirup && w_more_up) r_state <= S_MPRB;
                    else if (!r_dirup && w_more_dn) r_state <= S_MPRB;
                    else if (!w_more_up && !w_more_dn) r_state <= S_MOUT;
                    else r_dirup <= !r_dirup;
                end
                S_MPRB: begin
                    if (r_dirup) begin
                        if (w_stop) begin
                            r_up <= 9'(npcm_pkg::PaletteSize);
                        end else begin
                            if (w_d1 < r_bestd && w_d2 < r_bestd) begin
                                r_bestd <= w_d2;
                                r_best <= r_up[7:0];
                            end
                            r_up <= r_up + 9'd1;
                        end
                    end else begin
                        if (w_stop) begin
                            r_dn <= -9'sd1;
                        end else begin
                            if (w_d1 < r_bestd && w_d2 < r_bestd) begin
                                r_bestd <= w_d2;
                                r_best <= r_dn[7:0];
                            end
                            r_dn <= r_dn - 9'sd1;
                        end
                    end
                    r_dirup <= !r_dirup;
                    r_state <= S_MSEL;
                end
                S_MOUT: r_state <= S_DONE;
                S_DONE: begin
                    if (w_fire) begin
                        if (r_req.command == npcm_pkg::CMD_MAP) begin
                            r_res.palette_index <= r_best;
                            r_res.mapped_pixel <= {r_req.pixel_word[31:24], r_prd};
                        end else begin
                            r_res <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready) else $error("ready while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.data)))
        else $error("result changed while stalled");
    a_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MPRB) |-> (r_bestd <= npcm_pkg::StartDist))
        else $error("best distance grew");
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MPRB) |-> (r_dirup ? w_more_up : w_more_dn))
        else $error("probe on a stopped direction");
endmodule
`default_nettype wire

// ===== dv/tb_nearest_palette_color_mapper_core.sv =====
// tb_nearest_palette_color_mapper_core: self-checking bench for the palette mapper core
// depends on npcm_pkg, npcm_if and nearest_palette_color_mapper_core
`timescale 1ns / 100ps
`default_nettype none
module tb_nearest_palette_color_mapper_core;
    localparam int Entries = 256;
    localparam int RandItems = 780;
    localparam int MaxSorts = 4;

    typedef struct {
        npcm_pkg::t_cmd  cmd;
        logic [7:0]      idx;
        logic [31:0]     px;
        bit              typed;
        npcm_pkg::t_out  want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    npcm_in_if  in_ch ();
    npcm_out_if out_ch ();

    nearest_palette_color_mapper_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // own copy of the palette and the green start table
    logic [23:0] pal_mem [Entries];
    logic [7:0]  green_start [Entries];

    npcm_pkg::t_out pending_maps [$];
    int   mismatches = 0;
    bit   no_idle = 1'b0;

    // directed rows: loads, builds and unused commands carry their answer inline,
    // map rows are checked against the predictor
    t_dir_row dir_rows [17] = '{
        '{npcm_pkg::CMD_LOAD,  8'd0,   32'hffffffff, 1'b1, '0},
        '{npcm_pkg::CMD_LOAD,  8'd255, 32'h00000000, 1'b1, '0},
        '{npcm_pkg::CMD_LOAD,  8'd128, 32'h0000ff00, 1'b1, '0},
        '{npcm_pkg::CMD_LOAD,  8'd1,   32'h12ff0034, 1'b1, '0},
        '{npcm_pkg::CMD_BUILD, 8'd0,   32'h00000000, 1'b1, '0},
        '{npcm_pkg::CMD_MAP,   8'd0,   32'h00000000, 1'b0, '0},
        '{npcm_pkg::CMD_MAP,   8'd255, 32'hffffffff, 1'b0, '0},
        '{npcm_pkg::CMD_MAP,   8'd0,   32'h0000ff00, 1'b0, '0},
        '{npcm_pkg::CMD_MAP,   8'd0,   32'h80ff00ff, 1'b0, '0},
        '{npcm_pkg::CMD_NONE,  8'd0,   32'hffffffff, 1'b1, '0},
        '{npcm_pkg::CMD_NONE,  8'd255, 32'h00000000, 1'b1, '0},
        '{npcm_pkg::CMD_LOAD,  8'd7,   32'hab808080, 1'b1, '0},
        '{npcm_pkg::CMD_BUILD, 8'd255, 32'hffffffff, 1'b1, '0},
        '{npcm_pkg::CMD_MAP,   8'd0,   32'h7f808080, 1'b0, '0},
        '{npcm_pkg::CMD_MAP,   8'd0,   32'h01020304, 1'b0, '0},
        '{npcm_pkg::CMD_MAP,   8'd0,   32'hff00ff00, 1'b0, '0},
        '{npcm_pkg::CMD_MAP,   8'd0,   32'h00fe01fe, 1'b0, '0}
    };

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int absdiff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // selection sort by green, first smallest wins, then fill the start table
    function automatic void sort_by_green();
        int prev;
        int start;
        int pos;
        int val;
        logic [23:0] tmp;
        prev = 0;
        start = 0;
        for (int k = 0; k < npcm_pkg::PaletteSize; k++) begin
            pos = k;
            val = int'(pal_mem[k][15:8]);
            for (int m = k + 1; m < npcm_pkg::PaletteSize; m++) begin
                if (int'(pal_mem[m][15:8]) < val) begin
                    pos = m;
                    val = int'(pal_mem[m][15:8]);
                end
            end
            if (pos != k) begin
                tmp = pal_mem[k];
                pal_mem[k] = pal_mem[pos];
                pal_mem[pos] = tmp;
            end
            if (val != prev) begin
                green_start[prev] = 8'((start + k) >> 1);
                for (int m = prev + 1; m < val; m++) green_start[m] = 8'(k);
                prev = val;
                start = k;
            end
        end
        green_start[prev] = 8'((start + npcm_pkg::PaletteSize - 1) >> 1);
        for (int m = prev + 1; m < Entries; m++)
            green_start[m] = 8'(npcm_pkg::PaletteSize - 1);
    endfunction

    // one candidate probe; returns 0 once the walk in that direction stops
    function automatic bit probe_entry(int pos, int gkey, int b, int r,
                                       inout int bestd, inout int best);
        int d;
        if (gkey >= bestd) return 1'b0;
        d = absdiff(gkey, 0) + absdiff(int'(pal_mem[pos][7:0]), b);
        if (d < bestd) begin
            d += absdiff(int'(pal_mem[pos][23:16]), r);
            if (d < bestd) begin
                bestd = d;
                best = pos;
            end
        end
        return 1'b1;
    endfunction

    // outward green walk, upward candidate first in each round
    function automatic npcm_pkg::t_out nearest_color(logic [31:0] px);
        int b;
        int g;
        int r;
        int bestd;
        int best;
        int up;
        int dn;
        npcm_pkg::t_out res;
        b = int'(px[7:0]);
        g = int'(px[15:8]);
        r = int'(px[23:16]);
        bestd = int'(npcm_pkg::StartDist);
        best = 0;
        up = int'(green_start[g]);
        if (up > npcm_pkg::PaletteSize - 1) up = npcm_pkg::PaletteSize - 1;
        dn = up - 1;
        while (up < npcm_pkg::PaletteSize || dn >= 0) begin
            if (up < npcm_pkg::PaletteSize) begin
                if (probe_entry(up, int'(pal_mem[up][15:8]) - g, b, r, bestd, best)) up++;
                else up = npcm_pkg::PaletteSize;
            end
            if (dn >= 0) begin
                if (probe_entry(dn, g - int'(pal_mem[dn][15:8]), b, r, bestd, best)) dn--;
                else dn = -1;
            end
        end
        res.palette_index = 8'(best);
        res.mapped_pixel = {px[31:24], pal_mem[best]};
        return res;
    endfunction

    function automatic npcm_pkg::t_out apply_command(npcm_pkg::t_in it);
        npcm_pkg::t_out res;
        res = '0;
        case (npcm_pkg::t_cmd'(it.command))
            npcm_pkg::CMD_LOAD: begin
                if (int'(it.entry_index) < npcm_pkg::PaletteSize)
                    pal_mem[it.entry_index] = it.pixel_word[23:0];
            end
            npcm_pkg::CMD_BUILD: begin
                sort_by_green();
            end
            npcm_pkg::CMD_MAP: begin
                res = nearest_color(it.pixel_word);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, npcm_pkg::t_out got, npcm_pkg::t_out want);
        mismatches++;
        $display("%0t mismatch %s: got idx %0d px %08h, want idx %0d px %08h",
                 $realtime, what, got.palette_index, got.mapped_pixel,
                 want.palette_index, want.mapped_pixel);
    endtask

    // send one transaction after a random gap; valid stays high if the gap is 0
    task automatic send_item(npcm_pkg::t_in it, bit typed, npcm_pkg::t_out want);
        int gap;
        npcm_pkg::t_out res;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        res = apply_command(it);
        pending_maps.push_back(typed ? want : res);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_maps.size() != 0);
    endtask

    // result side: random stall per transaction, field-by-field compare
    initial begin
        int stall;
        npcm_pkg::t_out got;
        npcm_pkg::t_out want;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got = out_ch.data;
            if (pending_maps.size() == 0) begin
                report_mismatch("unexpected transaction", got, '0);
            end else begin
                want = pending_maps.pop_front();
                if (got.palette_index !== want.palette_index)
                    report_mismatch("palette_index", got, want);
                if (got.mapped_pixel !== want.mapped_pixel)
                    report_mismatch("mapped_pixel", got, want);
            end
        end
    end

    // stimulus
    initial begin
        npcm_pkg::t_in it;
        int sorts;
        int pick;
        int sent;
        logic [7:0] gsel;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        for (int k = 0; k < Entries; k++) begin
            pal_mem[k] = '0;
            green_start[k] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole palette first so nothing unwritten is ever read;
        // a few clustered greens give ties and duplicate runs
        for (int k = 0; k < npcm_pkg::PaletteSize; k++) begin
            it.command = npcm_pkg::CMD_LOAD;
            it.entry_index = 8'(k);
            it.pixel_word = $urandom;
            if (k % 5 == 0) it.pixel_word[15:8] = 8'($urandom_range(0, 3) * 85);
            send_item(it, 1'b1, '0);
        end

        for (int n = 0; n < $size(dir_rows); n++) begin
            it.command = dir_rows[n].cmd;
            it.entry_index = dir_rows[n].idx;
            it.pixel_word = dir_rows[n].px;
            send_item(it, dir_rows[n].typed, dir_rows[n].want);
        end
        // hold off until every result is back
        drain();

        sorts = 0;
        sent = 0;
        while (sent < RandItems) begin
            if (sent % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
            if (sent % 200 == 199) drain();
            pick = $urandom_range(0, 999);
            it.entry_index = 8'($urandom);
            it.pixel_word = $urandom;
            if (pick < 8 && sorts < MaxSorts) begin
                it.command = npcm_pkg::CMD_BUILD;
                sorts++;
            end else if (pick < 230) begin
                it.command = npcm_pkg::CMD_LOAD;
                if ($urandom_range(0, 3) == 0)
                    it.pixel_word[15:8] = 8'($urandom_range(0, 1) * 255);
            end else if (pick < 980) begin
                it.command = npcm_pkg::CMD_MAP;
                // aim some pixels at or right next to a stored color
                if ($urandom_range(0, 3) == 0) begin
                    gsel = 8'($urandom);
                    it.pixel_word[23:0] = pal_mem[gsel] ^ 24'($urandom_range(0, 3));
                end
            end else begin
                it.command = npcm_pkg::CMD_NONE;
            end
            send_item(it, 1'b0, '0);
            if (it.command != npcm_pkg::CMD_NONE) sent++;
        end
        no_idle = 1'b0;
        drain();
        repeat (40) @(posedge i_clk);

        if (mismatches == 0 && pending_maps.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog: sorts of the full palette dominate the run time
    initial begin
        #100ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
